@@ rtl/pwt_pkg.sv @@
`timescale 1ns / 1ps
package pwt_pkg;

    // Field and register widths.
    localparam int ERR_W   = 16;
    localparam int DELTA_W = 17;
    localparam int INTEG_W = 32;
    localparam int GAIN_W  = 24;
    localparam int STEP_W  = 23;
    localparam int CNT_W   = 24;
    localparam int SUM_W   = 48;
    localparam int MEAN_W  = 32;
    localparam int STEER_W = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;

    // Shared divider widths.
    localparam int DIVD_W = 48;
    localparam int DIVS_W = 24;

    // Reset values of the tuning registers.
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 24'sd3277;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 24'sd66;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 24'sd196608;
    localparam logic [STEP_W-1:0] STEP_P_RST = 23'd655;
    localparam logic [STEP_W-1:0] STEP_I_RST = 23'd7;
    localparam logic [STEP_W-1:0] STEP_D_RST = 23'd6554;
    localparam logic [15:0] WARMUP_RST  = 16'd100;
    localparam logic [15:0] MIN_RUN_RST = 16'd300;

    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
    localparam logic signed [STEER_W-1:0] STEER_POS = 16'sd16384;
    localparam logic signed [STEER_W-1:0] STEER_NEG = -16'sd16384;

    // Operation codes of an input word.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TUNE   = 1'b1;

    // Gain and step target codes.
    localparam logic [1:0] TGT_P = 2'd0;
    localparam logic [1:0] TGT_I = 2'd1;
    localparam logic [1:0] TGT_D = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_STEP_P  = 3'd3,
        CFG_STEP_I  = 3'd4,
        CFG_STEP_D  = 3'd5,
        CFG_WARMUP  = 3'd6,
        CFG_MIN_RUN = 3'd7
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_KP,
        S_KD,
        S_KI,
        S_ACC,
        S_STEER,
        S_DIV,
        S_DEC,
        S_SCALE,
        S_SCALE_W,
        S_FINAL,
        S_DONE
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    // Saturate a widened gain sum to the signed gain range.
    function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [GAIN_W+1:0] v);
        logic signed [GAIN_W+1:0] hi;
        logic signed [GAIN_W+1:0] lo;
        hi = {3'b000, {(GAIN_W-1){1'b1}}};
        lo = {3'b111, {(GAIN_W-1){1'b0}}};
        if (v > hi) begin
            sat_gain = hi[GAIN_W-1:0];
        end else if (v < lo) begin
            sat_gain = lo[GAIN_W-1:0];
        end else begin
            sat_gain = v[GAIN_W-1:0];
        end
    endfunction

endpackage

@@ rtl/pwt_in_if.sv @@
`timescale 1ns / 1ps
interface pwt_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic signed [pwt_pkg::ERR_W-1:0]      track_error;

    modport source (output valid, output operation, output track_error, input ready);
    modport sink   (input valid, input operation, input track_error, output ready);
endinterface

@@ rtl/pwt_out_if.sv @@
`timescale 1ns / 1ps
interface pwt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pwt_pkg::STEER_W-1:0]    steer_cmd;
    logic signed [pwt_pkg::GAIN_W-1:0]     cur_gain_p;
    logic signed [pwt_pkg::GAIN_W-1:0]     cur_gain_i;
    logic signed [pwt_pkg::GAIN_W-1:0]     cur_gain_d;
    logic [pwt_pkg::MEAN_W-1:0]            run_mean_error;
    logic                                  improved;

    modport source (output valid, output steer_cmd, output cur_gain_p, output cur_gain_i,
                    output cur_gain_d, output run_mean_error, output improved, input ready);
    modport sink   (input valid, input steer_cmd, input cur_gain_p, input cur_gain_i,
                    input cur_gain_d, input run_mean_error, input improved, output ready);
endinterface

@@ rtl/pid_with_twiddle_tuning.sv @@
`timescale 1ns / 1ps
// PID steering loop with twiddle gain tuning.
// Input channel i_in carries an operation bit and a Q8.8 error. A sample word
// updates the error state and yields a Q2.14 steer command; a tune word closes
// a run, yields the mean squared error and moves the gains by twiddle.
// Output channel o_out carries the steer command, the three gains after the
// word, the run mean and an improvement flag; one result word per input word.
// A sample word makes four passes through the one shared 24x32 multiplier,
// for the square and the P, D and I terms, before its result is valid. A
// tune word past warm-up runs the one-bit-a-cycle divider for the mean,
// plus one multiplier pass when a step is rescaled by 1.1 or 0.9.
// Throughput: one word at a time; i_in.ready is high only while the sequencer
// is idle. A finished result waits in the output register, so the next word
// can be accepted while the receiver stalls; a further result then waits
// until the held one is taken.
// Reset (synchronous, active low) restores the default gains, steps and run
// lengths and clears the error state. Configuration writes on i_cfg_we must
// be made only while idle; writing a gain or step also loads the working value.
module pid_with_twiddle_tuning (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pwt_in_if.sink                              i_in,
    pwt_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [pwt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pwt_pkg::CFG_W-1:0]           i_cfg_data
);

    pwt_pkg::t_state r_state, n_state;

    // Error and run state.
    logic signed [pwt_pkg::ERR_W-1:0]   r_last;
    logic signed [pwt_pkg::DELTA_W-1:0] r_delta;
    logic signed [pwt_pkg::INTEG_W-1:0] r_integ;
    logic [pwt_pkg::SUM_W-1:0]          r_sq_sum;
    logic [pwt_pkg::CNT_W-1:0]          r_count;
    logic                               r_sq_en;
    logic [pwt_pkg::MEAN_W-1:0]         r_best;
    logic                               r_best_valid;
    logic [1:0]                         r_target;
    logic                               r_going_up;
    logic [1:0]                         r_t;
    logic                               r_scale_up;
    logic [15:0]                        r_warmup;
    logic [15:0]                        r_min_run;

    logic signed [pwt_pkg::GAIN_W-1:0]  r_gain [3];
    logic [pwt_pkg::STEP_W-1:0]         r_step [3];

    // Work results.
    logic signed [pwt_pkg::ACC_W-1:0]   r_acc;
    logic signed [pwt_pkg::STEER_W-1:0] r_steer;
    logic [pwt_pkg::MEAN_W-1:0]         r_mean;
    logic                               r_improved;

    // Output register.
    logic                               r_out_valid;
    logic signed [pwt_pkg::STEER_W-1:0] r_o_steer;
    logic signed [pwt_pkg::GAIN_W-1:0]  r_o_gain_p;
    logic signed [pwt_pkg::GAIN_W-1:0]  r_o_gain_i;
    logic signed [pwt_pkg::GAIN_W-1:0]  r_o_gain_d;
    logic [pwt_pkg::MEAN_W-1:0]         r_o_mean;
    logic                               r_o_improved;

    // Shared units.
    logic signed [pwt_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [pwt_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [pwt_pkg::PROD_W-1:0]  w_prod;
    pwt_pkg::t_div_req                  w_div_req;
    logic                               w_div_done;
    logic [pwt_pkg::DIVD_W-1:0]         w_div_quo;

    logic                               w_accept;
    logic                               w_load_out;
    logic                               w_run_ok;
    logic [1:0]                         w_sel;
    logic [1:0]                         w_tgt_cl;
    logic signed [pwt_pkg::GAIN_W-1:0]  w_gsel;
    logic [pwt_pkg::STEP_W-1:0]         w_ssel;
    logic signed [pwt_pkg::GAIN_W+1:0]  w_g_up;
    logic signed [pwt_pkg::GAIN_W+1:0]  w_g_dn;
    logic [pwt_pkg::STEP_W+3:0]         w_scaled;
    logic [pwt_pkg::STEP_W:0]           w_q0;
    logic [pwt_pkg::STEP_W+3:0]         w_q0x10;
    logic [pwt_pkg::STEP_W+3:0]         w_q_rem;
    logic [pwt_pkg::STEP_W:0]           w_quot;
    logic signed [pwt_pkg::DELTA_W-1:0] w_e_delta;
    logic signed [pwt_pkg::INTEG_W:0]   w_integ_sum;
    logic [pwt_pkg::SUM_W:0]            w_sq_next;
    logic signed [pwt_pkg::ACC_W-1:0]   w_neg;
    logic signed [pwt_pkg::ACC_W-1:0]   w_rnd;

    // Rounding half and clamp bound of the Q.24 steer sum.
    localparam logic signed [pwt_pkg::ACC_W-1:0] ACC_RND   =
        {{(pwt_pkg::ACC_W-10){1'b0}}, 10'd512};
    localparam logic signed [pwt_pkg::ACC_W-1:0] ACC_BOUND =
        {{(pwt_pkg::ACC_W-25){1'b0}}, 1'b1, 24'd0};

    // Reciprocal of ten in Q.26, rounded down. The product quotient is at most
    // one short for any scaled step, so one compare afterwards makes it exact.
    localparam int TENTH_SHIFT = 26;
    localparam logic signed [pwt_pkg::MUL_A_W-1:0] TENTH_RECIP = 24'sd6710886;

    pwt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    pwt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign i_in.ready = (r_state == pwt_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load_out = (r_state == pwt_pkg::S_DONE) && (!r_out_valid || o_out.ready);
    assign w_run_ok   = r_count > {8'd0, r_warmup};

    // Target code three acts as the derivative gain.
    assign w_tgt_cl = (r_target > pwt_pkg::TGT_D) ? pwt_pkg::TGT_D : r_target;

    // One gain and step read port, its index chosen by the sequencer.
    always_comb begin
        case (r_state)
            pwt_pkg::S_DEC:   w_sel = r_best_valid ? w_tgt_cl : pwt_pkg::TGT_P;
            pwt_pkg::S_FINAL: w_sel = w_tgt_cl;
            default:          w_sel = r_t;
        endcase
    end

    assign w_gsel = (w_sel == pwt_pkg::TGT_P) ? r_gain[0] :
                    (w_sel == pwt_pkg::TGT_I) ? r_gain[1] : r_gain[2];
    assign w_ssel = (w_sel == pwt_pkg::TGT_P) ? r_step[0] :
                    (w_sel == pwt_pkg::TGT_I) ? r_step[1] : r_step[2];
    assign w_g_up = {{2{w_gsel[pwt_pkg::GAIN_W-1]}}, w_gsel} + {3'b000, w_ssel};
    assign w_g_dn = {{2{w_gsel[pwt_pkg::GAIN_W-1]}}, w_gsel} - {2'b00, w_ssel, 1'b0};

    // Step times 11 or 9, plus the rounding half of a division by ten.
    assign w_scaled = r_scale_up
        ? ({1'b0, w_ssel, 3'b000} + {3'b000, w_ssel, 1'b0} + {4'b0000, w_ssel} + 27'd5)
        : ({1'b0, w_ssel, 3'b000} + {4'b0000, w_ssel} + 27'd5);

    // Division by ten from the reciprocal product, with one correction step.
    assign w_q0    = w_prod[TENTH_SHIFT+pwt_pkg::STEP_W:TENTH_SHIFT];
    assign w_q0x10 = {w_q0, 3'b000} + {2'b00, w_q0, 1'b0};
    assign w_q_rem = w_scaled - w_q0x10;
    assign w_quot  = w_q0 + {{pwt_pkg::STEP_W{1'b0}}, (w_q_rem >= 27'd10)};

    // Sample arithmetic.
    assign w_e_delta   = {i_in.track_error[pwt_pkg::ERR_W-1], i_in.track_error}
                       - {r_last[pwt_pkg::ERR_W-1], r_last};
    assign w_integ_sum = {r_integ[pwt_pkg::INTEG_W-1], r_integ}
                       + {{(pwt_pkg::INTEG_W-pwt_pkg::ERR_W+1){i_in.track_error[pwt_pkg::ERR_W-1]}},
                          i_in.track_error};
    assign w_sq_next   = {1'b0, r_sq_sum} + {17'd0, w_prod[31:0]};
    assign w_neg       = -r_acc;
    assign w_rnd       = (w_neg + ACC_RND) >>> 10;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pwt_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_in.operation == pwt_pkg::OP_SAMPLE) begin
                        n_state = pwt_pkg::S_SQ;
                    end else if (w_run_ok) begin
                        n_state = pwt_pkg::S_DIV;
                    end else begin
                        n_state = pwt_pkg::S_DEC;
                    end
                end
            end
            pwt_pkg::S_SQ:    n_state = pwt_pkg::S_KP;
            pwt_pkg::S_KP:    n_state = pwt_pkg::S_KD;
            pwt_pkg::S_KD:    n_state = pwt_pkg::S_KI;
            pwt_pkg::S_KI:    n_state = pwt_pkg::S_ACC;
            pwt_pkg::S_ACC:   n_state = pwt_pkg::S_STEER;
            pwt_pkg::S_STEER: n_state = pwt_pkg::S_DONE;
            pwt_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = pwt_pkg::S_DEC;
                end
            end
            pwt_pkg::S_DEC: begin
                if (!r_best_valid) begin
                    n_state = pwt_pkg::S_DONE;
                end else if (r_mean < r_best && r_count > {8'd0, r_min_run}) begin
                    n_state = pwt_pkg::S_SCALE;
                end else if (r_going_up) begin
                    n_state = pwt_pkg::S_FINAL;
                end else begin
                    n_state = pwt_pkg::S_SCALE;
                end
            end
            pwt_pkg::S_SCALE:   n_state = pwt_pkg::S_SCALE_W;
            pwt_pkg::S_SCALE_W: n_state = pwt_pkg::S_FINAL;
            pwt_pkg::S_FINAL:   n_state = pwt_pkg::S_DONE;
            pwt_pkg::S_DONE: begin
                if (w_load_out) begin
                    n_state = pwt_pkg::S_IDLE;
                end
            end
            default: n_state = pwt_pkg::S_IDLE;
        endcase
    end

    // Unit controls.
    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_div_req = '0;
        unique case (r_state)
            pwt_pkg::S_IDLE: begin
                w_div_req.start    = w_accept && (i_in.operation == pwt_pkg::OP_TUNE) && w_run_ok;
                w_div_req.dividend = r_sq_sum;
                w_div_req.divisor  = r_count - {8'd0, r_warmup};
            end
            pwt_pkg::S_SQ: begin
                w_mul_a = {{(pwt_pkg::MUL_A_W-pwt_pkg::ERR_W){r_last[pwt_pkg::ERR_W-1]}}, r_last};
                w_mul_b = {{(pwt_pkg::MUL_B_W-pwt_pkg::ERR_W){r_last[pwt_pkg::ERR_W-1]}}, r_last};
            end
            pwt_pkg::S_KP: begin
                w_mul_a = r_gain[0];
                w_mul_b = {{(pwt_pkg::MUL_B_W-pwt_pkg::ERR_W){r_last[pwt_pkg::ERR_W-1]}}, r_last};
            end
            pwt_pkg::S_KD: begin
                w_mul_a = r_gain[2];
                w_mul_b = {{(pwt_pkg::MUL_B_W-pwt_pkg::DELTA_W){r_delta[pwt_pkg::DELTA_W-1]}},
                           r_delta};
            end
            pwt_pkg::S_KI: begin
                w_mul_a = r_gain[1];
                w_mul_b = r_integ;
            end
            pwt_pkg::S_SCALE: begin
                w_mul_a = TENTH_RECIP;
                w_mul_b = {{(pwt_pkg::MUL_B_W-pwt_pkg::STEP_W-4){1'b0}}, w_scaled};
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    // Control registers and outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pwt_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_last       <= '0;
            r_delta      <= '0;
            r_integ      <= '0;
            r_sq_sum     <= '0;
            r_count      <= '0;
            r_best       <= '0;
            r_best_valid <= 1'b0;
            r_target     <= pwt_pkg::TGT_P;
            r_going_up   <= 1'b1;
            r_warmup     <= pwt_pkg::WARMUP_RST;
            r_min_run    <= pwt_pkg::MIN_RUN_RST;
            r_gain[0]    <= pwt_pkg::GAIN_P_RST;
            r_gain[1]    <= pwt_pkg::GAIN_I_RST;
            r_gain[2]    <= pwt_pkg::GAIN_D_RST;
            r_step[0]    <= pwt_pkg::STEP_P_RST;
            r_step[1]    <= pwt_pkg::STEP_I_RST;
            r_step[2]    <= pwt_pkg::STEP_D_RST;
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (i_cfg_we) begin
                unique case (pwt_pkg::t_cfg_idx'(i_cfg_idx))
                    pwt_pkg::CFG_GAIN_P:  r_gain[0] <= i_cfg_data;
                    pwt_pkg::CFG_GAIN_I:  r_gain[1] <= i_cfg_data;
                    pwt_pkg::CFG_GAIN_D:  r_gain[2] <= i_cfg_data;
                    pwt_pkg::CFG_STEP_P:  r_step[0] <= i_cfg_data[pwt_pkg::STEP_W-1:0];
                    pwt_pkg::CFG_STEP_I:  r_step[1] <= i_cfg_data[pwt_pkg::STEP_W-1:0];
                    pwt_pkg::CFG_STEP_D:  r_step[2] <= i_cfg_data[pwt_pkg::STEP_W-1:0];
                    pwt_pkg::CFG_WARMUP:  r_warmup  <= i_cfg_data[15:0];
                    pwt_pkg::CFG_MIN_RUN: r_min_run <= i_cfg_data[15:0];
                    default:              r_warmup  <= r_warmup;
                endcase
            end

            // Output register.
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                pwt_pkg::S_IDLE: begin
                    if (w_accept && i_in.operation == pwt_pkg::OP_SAMPLE) begin
                        r_last  <= i_in.track_error;
                        r_delta <= w_e_delta;
                        if (w_integ_sum[pwt_pkg::INTEG_W] != w_integ_sum[pwt_pkg::INTEG_W-1]) begin
                            r_integ <= w_integ_sum[pwt_pkg::INTEG_W]
                                     ? {1'b1, {(pwt_pkg::INTEG_W-1){1'b0}}}
                                     : {1'b0, {(pwt_pkg::INTEG_W-1){1'b1}}};
                        end else begin
                            r_integ <= w_integ_sum[pwt_pkg::INTEG_W-1:0];
                        end
                        r_sq_en <= w_run_ok;
                        if (r_count != pwt_pkg::CNT_MAX) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                pwt_pkg::S_KP: begin
                    if (r_sq_en) begin
                        r_sq_sum <= w_sq_next[pwt_pkg::SUM_W] ? pwt_pkg::SUM_MAX
                                                              : w_sq_next[pwt_pkg::SUM_W-1:0];
                    end
                end
                pwt_pkg::S_DEC: begin
                    r_sq_sum <= '0;
                    r_count  <= '0;
                    if (!r_best_valid) begin
                        r_best_valid <= 1'b1;
                        r_best       <= r_mean;
                        r_gain[0]    <= pwt_pkg::sat_gain(w_g_up);
                    end else begin
                        r_last  <= '0;
                        r_delta <= '0;
                        r_integ <= '0;
                        r_t     <= w_tgt_cl;
                        if (r_mean < r_best && r_count > {8'd0, r_min_run}) begin
                            r_best     <= r_mean;
                            r_scale_up <= 1'b1;
                            r_target   <= (w_tgt_cl == pwt_pkg::TGT_D) ? pwt_pkg::TGT_P
                                                                       : w_tgt_cl + 1'b1;
                            r_going_up <= 1'b1;
                        end else if (r_going_up) begin
                            r_going_up <= 1'b0;
                        end else begin
                            r_gain[w_tgt_cl] <= pwt_pkg::sat_gain(w_g_up);
                            r_scale_up <= 1'b0;
                            r_target   <= (w_tgt_cl == pwt_pkg::TGT_D) ? pwt_pkg::TGT_P
                                                                       : w_tgt_cl + 1'b1;
                            r_going_up <= 1'b1;
                        end
                    end
                end
                pwt_pkg::S_SCALE_W: begin
                    r_step[r_t] <= w_quot[pwt_pkg::STEP_W] ? pwt_pkg::STEP_MAX
                                                           : w_quot[pwt_pkg::STEP_W-1:0];
                end
                pwt_pkg::S_FINAL: begin
                    r_gain[w_tgt_cl] <= r_going_up ? pwt_pkg::sat_gain(w_g_up)
                                                   : pwt_pkg::sat_gain(w_g_dn);
                end
                default: begin
                    r_sq_en <= r_sq_en;
                end
            endcase
        end
    end

    // Work result and output payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            pwt_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_improved <= 1'b0;
                    r_steer    <= '0;
                    r_mean     <= (i_in.operation == pwt_pkg::OP_TUNE && !w_run_ok)
                                ? pwt_pkg::MEAN_MAX : '0;
                end
            end
            pwt_pkg::S_KD:  r_acc <= {{2{w_prod[pwt_pkg::PROD_W-1]}}, w_prod};
            pwt_pkg::S_KI:  r_acc <= r_acc + {{2{w_prod[pwt_pkg::PROD_W-1]}}, w_prod};
            pwt_pkg::S_ACC: r_acc <= r_acc + {{2{w_prod[pwt_pkg::PROD_W-1]}}, w_prod};
            pwt_pkg::S_STEER: begin
                if (w_neg >= ACC_BOUND) begin
                    r_steer <= pwt_pkg::STEER_POS;
                end else if (w_neg <= -ACC_BOUND) begin
                    r_steer <= pwt_pkg::STEER_NEG;
                end else begin
                    r_steer <= w_rnd[pwt_pkg::STEER_W-1:0];
                end
            end
            pwt_pkg::S_DIV: begin
                if (w_div_done) begin
                    r_mean <= (w_div_quo[pwt_pkg::DIVD_W-1:pwt_pkg::MEAN_W] != '0)
                            ? pwt_pkg::MEAN_MAX : w_div_quo[pwt_pkg::MEAN_W-1:0];
                end
            end
            pwt_pkg::S_DEC: begin
                if (!r_best_valid || (r_mean < r_best && r_count > {8'd0, r_min_run})) begin
                    r_improved <= 1'b1;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase

        if (w_load_out) begin
            r_o_steer    <= r_steer;
            r_o_gain_p   <= r_gain[0];
            r_o_gain_i   <= r_gain[1];
            r_o_gain_d   <= r_gain[2];
            r_o_mean     <= r_mean;
            r_o_improved <= r_improved;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.steer_cmd      = r_o_steer;
    assign o_out.cur_gain_p     = r_o_gain_p;
    assign o_out.cur_gain_i     = r_o_gain_i;
    assign o_out.cur_gain_d     = r_o_gain_d;
    assign o_out.run_mean_error = r_o_mean;
    assign o_out.improved       = r_o_improved;

    // Once a best error is recorded it stays recorded.
    a_best_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_valid |=> r_best_valid)
        else $error("best error record was lost");

    // The target rotation never reaches code three.
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target != 2'd3)
        else $error("tune target left the P, I, D rotation");

    // The steer command stays within minus one to one.
    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.steer_cmd <= pwt_pkg::STEER_POS &&
                         o_out.steer_cmd >= pwt_pkg::STEER_NEG))
        else $error("steer command out of range");

    // The divider finishes only while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == pwt_pkg::S_DIV))
        else $error("divider finished outside a wait state");

endmodule

@@ rtl/pwt_mul.sv @@
`timescale 1ns / 1ps
module pwt_mul (
    input  logic                                  i_clk,
    input  logic signed [pwt_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [pwt_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [pwt_pkg::PROD_W-1:0]     o_prod
);

    logic signed [pwt_pkg::PROD_W-1:0] r_prod;

    // One signed product per cycle, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/pwt_div.sv @@
`timescale 1ns / 1ps
module pwt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pwt_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [pwt_pkg::DIVD_W-1:0]    o_quo
);

    localparam int CNT_W = $clog2(pwt_pkg::DIVD_W + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [pwt_pkg::DIVS_W:0]      r_rem;
    logic [pwt_pkg::DIVD_W-1:0]    r_quo;
    logic [pwt_pkg::DIVS_W-1:0]    r_dvs;

    logic [pwt_pkg::DIVS_W:0]      w_rem_sh;
    logic [pwt_pkg::DIVS_W+1:0]    w_diff;

    // One quotient bit per cycle, restoring form.
    assign w_rem_sh = {r_rem[pwt_pkg::DIVS_W-1:0], r_quo[pwt_pkg::DIVD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(pwt_pkg::DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[pwt_pkg::DIVS_W+1]) begin
                r_rem <= w_diff[pwt_pkg::DIVS_W:0];
                r_quo <= {r_quo[pwt_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[pwt_pkg::DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    // One expected result word.
    typedef struct {
        logic signed [pwt_pkg::STEER_W-1:0] steer_cmd;
        logic signed [pwt_pkg::GAIN_W-1:0]  gain_p;
        logic signed [pwt_pkg::GAIN_W-1:0]  gain_i;
        logic signed [pwt_pkg::GAIN_W-1:0]  gain_d;
        logic [pwt_pkg::MEAN_W-1:0]         mean;
        logic                               improved;
    } t_result;

    // One input word waiting to be offered.
    typedef struct {
        logic                               op;
        logic signed [pwt_pkg::ERR_W-1:0]   err;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pwt_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pwt_pkg::CFG_W-1:0] i_cfg_data = '0;

    pwt_in_if  in_ch ();
    pwt_out_if out_ch ();

    pid_with_twiddle_tuning dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_word   pending_words[$];
    t_result expected_results[$];
    int      fail_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_request_id = 0;
    int      hold_served_id = 0;
    int      hold_left = 0;

    // Loop state mirrored from the block.
    longint  init_gain[3];
    longint  init_step[3];
    longint  warmup;
    longint  min_run;
    longint  last_err, err_delta, err_integral, sq_sum, sample_cnt;
    longint  best_err;
    bit      best_valid;
    longint  gain[3];
    longint  step[3];
    int      target;
    bit      going_up;

    function automatic longint clamp_gain(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint rescale_step(longint s, longint num);
        longint r;
        r = (s * num + 5) / 10;
        return (r > longint'(pwt_pkg::STEP_MAX)) ? longint'(pwt_pkg::STEP_MAX) : r;
    endfunction

    function automatic longint steer_of_state();
        longint acc;
        longint v;
        longint bound;
        acc = gain[0] * last_err + gain[2] * err_delta + gain[1] * err_integral;
        v = -acc;
        bound = 64'sd16384 <<< 10;
        if (v >= bound) return 16384;
        if (v <= -bound) return -16384;
        return ((v + bound + 512) >>> 10) - 16384;
    endfunction

    task automatic reset_loop_state();
        init_gain[0] = pwt_pkg::GAIN_P_RST;
        init_gain[1] = pwt_pkg::GAIN_I_RST;
        init_gain[2] = pwt_pkg::GAIN_D_RST;
        init_step[0] = pwt_pkg::STEP_P_RST;
        init_step[1] = pwt_pkg::STEP_I_RST;
        init_step[2] = pwt_pkg::STEP_D_RST;
        warmup = pwt_pkg::WARMUP_RST;
        min_run = pwt_pkg::MIN_RUN_RST;
        last_err = 0; err_delta = 0; err_integral = 0; sq_sum = 0; sample_cnt = 0;
        best_err = 0; best_valid = 1'b0;
        for (int k = 0; k < 3; k++) begin
            gain[k] = init_gain[k];
            step[k] = init_step[k];
        end
        target = 0;
        going_up = 1'b1;
    endtask

    // Work out the result of one accepted word and queue it.
    task automatic predict_word(input logic op, input logic signed [pwt_pkg::ERR_W-1:0] err);
        t_result r;
        longint  e, s, q, run_len, mean, steer;
        bit      impr;
        int      t;
        steer = 0; mean = 0; impr = 1'b0;
        if (op == pwt_pkg::OP_SAMPLE) begin
            e = err;
            err_delta = e - last_err;
            last_err = e;
            s = err_integral + e;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            err_integral = s;
            if (sample_cnt > warmup) begin
                sq_sum = sq_sum + e * e;
                if (sq_sum > longint'(pwt_pkg::SUM_MAX)) sq_sum = pwt_pkg::SUM_MAX;
            end
            if (sample_cnt < longint'(pwt_pkg::CNT_MAX)) sample_cnt++;
            steer = steer_of_state();
        end else begin
            run_len = sample_cnt;
            if (sample_cnt > warmup) begin
                q = sq_sum / (sample_cnt - warmup);
                mean = (q > longint'(pwt_pkg::MEAN_MAX)) ? longint'(pwt_pkg::MEAN_MAX) : q;
            end else begin
                mean = pwt_pkg::MEAN_MAX;
            end
            sq_sum = 0;
            sample_cnt = 0;
            if (!best_valid) begin
                best_valid = 1'b1;
                best_err = mean;
                impr = 1'b1;
                gain[0] = clamp_gain(gain[0] + step[0]);
            end else begin
                last_err = 0; err_delta = 0; err_integral = 0;
                t = target;
                if (mean < best_err && run_len > min_run) begin
                    best_err = mean;
                    impr = 1'b1;
                    step[t] = rescale_step(step[t], 11);
                    target = (t + 1) % 3;
                    going_up = 1'b1;
                end else if (going_up) begin
                    going_up = 1'b0;
                end else begin
                    gain[t] = clamp_gain(gain[t] + step[t]);
                    step[t] = rescale_step(step[t], 9);
                    target = (t + 1) % 3;
                    going_up = 1'b1;
                end
                t = target;
                if (going_up) gain[t] = clamp_gain(gain[t] + step[t]);
                else gain[t] = clamp_gain(gain[t] - 2 * step[t]);
            end
        end
        r.steer_cmd = steer[pwt_pkg::STEER_W-1:0];
        r.gain_p = gain[0][pwt_pkg::GAIN_W-1:0];
        r.gain_i = gain[1][pwt_pkg::GAIN_W-1:0];
        r.gain_d = gain[2][pwt_pkg::GAIN_W-1:0];
        r.mean = mean[pwt_pkg::MEAN_W-1:0];
        r.improved = impr;
        expected_results.push_back(r);
    endtask

    // Input driver: offers queued words and predicts each accepted one.
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(in_ch.operation, in_ch.track_error);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.operation <= w.op;
                    in_ch.track_error <= w.err;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with an occasional long hold-off.
    always @(posedge i_clk) begin
        if (hold_request_id != hold_served_id) begin
            hold_served_id <= hold_request_id;
            hold_left <= 400;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: each result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result x;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                x = expected_results.pop_front();
                if (out_ch.steer_cmd !== x.steer_cmd) begin
                    $error("steer_cmd expected %0d got %0d", x.steer_cmd, out_ch.steer_cmd);
                    fail_count++;
                end
                if (out_ch.cur_gain_p !== x.gain_p) begin
                    $error("cur_gain_p expected %0d got %0d", x.gain_p, out_ch.cur_gain_p);
                    fail_count++;
                end
                if (out_ch.cur_gain_i !== x.gain_i) begin
                    $error("cur_gain_i expected %0d got %0d", x.gain_i, out_ch.cur_gain_i);
                    fail_count++;
                end
                if (out_ch.cur_gain_d !== x.gain_d) begin
                    $error("cur_gain_d expected %0d got %0d", x.gain_d, out_ch.cur_gain_d);
                    fail_count++;
                end
                if (out_ch.run_mean_error !== x.mean) begin
                    $error("run_mean_error expected %0d got %0d", x.mean,
                           out_ch.run_mean_error);
                    fail_count++;
                end
                if (out_ch.improved !== x.improved) begin
                    $error("improved expected %0d got %0d", x.improved, out_ch.improved);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_word(input logic op, input int err);
        t_word w;
        w.op = op;
        w.err = err[pwt_pkg::ERR_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        wait (pending_words.size() == 0 && !in_ch.valid && expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input pwt_pkg::t_cfg_idx idx,
                             input logic [pwt_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= pwt_pkg::CFG_GAIN_D) begin
            init_gain[idx] = longint'(signed'(data));
            gain[idx] = init_gain[idx];
        end else if (idx <= pwt_pkg::CFG_STEP_D) begin
            init_step[idx - pwt_pkg::CFG_STEP_P] = data & pwt_pkg::STEP_MAX;
            step[idx - pwt_pkg::CFG_STEP_P] = init_step[idx - pwt_pkg::CFG_STEP_P];
        end else if (idx == pwt_pkg::CFG_WARMUP) begin
            warmup = data[15:0];
        end else begin
            min_run = data[15:0];
        end
    endtask

    // Either a small value up to small_max or a full random word.
    function automatic logic [pwt_pkg::CFG_W-1:0] pick_cfg(input int unsigned small_max);
        int unsigned v;
        v = $urandom_range(1) ? $urandom_range(small_max) : $urandom;
        return v[pwt_pkg::CFG_W-1:0];
    endfunction

    function automatic logic [pwt_pkg::CFG_W-1:0] pick_small(input int unsigned small_max);
        int unsigned v;
        v = $urandom_range(small_max);
        return v[pwt_pkg::CFG_W-1:0];
    endfunction

    function automatic int random_error();
        case ($urandom_range(3))
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(512) - 256;
            2: return $urandom_range(1) ? 32767 : -32768;
            default: return $urandom_range(8192) - 4096;
        endcase
    endfunction

    // Random runs: sample sequences closed by a tune word, plus some noise.
    task automatic queue_runs(input int n_items, input bit with_hold);
        int queued;
        int len;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(9) == 0) begin
                queue_word(pwt_pkg::OP_TUNE, $urandom_range(65535));
                queued++;
            end else begin
                len = $urandom_range(14);
                for (int k = 0; k < len; k++) queue_word(pwt_pkg::OP_SAMPLE, random_error());
                queue_word(pwt_pkg::OP_TUNE, $urandom_range(65535));
                queued += len + 1;
            end
        end
        if (with_hold) hold_request_id++;
    endtask

    task automatic random_config();
        write_reg(pwt_pkg::CFG_GAIN_P, pick_cfg(16383));
        write_reg(pwt_pkg::CFG_GAIN_I, pick_cfg(255));
        write_reg(pwt_pkg::CFG_GAIN_D, pick_cfg(262143));
        write_reg(pwt_pkg::CFG_STEP_P, pick_cfg(4095));
        write_reg(pwt_pkg::CFG_STEP_I, pick_cfg(63));
        write_reg(pwt_pkg::CFG_STEP_D, pick_small(8191));
        write_reg(pwt_pkg::CFG_WARMUP, pick_small(4));
        write_reg(pwt_pkg::CFG_MIN_RUN, pick_small(8));
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = pwt_pkg::OP_SAMPLE;
        in_ch.track_error = '0;
        out_ch.ready = 1'b0;
        reset_loop_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset settings: tunes before warm-up ends,
        // field extremes, and every twiddle branch but the improving one.
        queue_word(pwt_pkg::OP_TUNE, 0);
        queue_word(pwt_pkg::OP_SAMPLE, 32767);
        queue_word(pwt_pkg::OP_SAMPLE, -32768);
        queue_word(pwt_pkg::OP_SAMPLE, 0);
        queue_word(pwt_pkg::OP_SAMPLE, 1);
        queue_word(pwt_pkg::OP_SAMPLE, -1);
        queue_word(pwt_pkg::OP_TUNE, -1);
        queue_word(pwt_pkg::OP_TUNE, 0);
        queue_word(pwt_pkg::OP_TUNE, 0);
        wait_drained();

        // Extreme settings: saturated gains, saturated and zero steps, no warm-up.
        write_reg(pwt_pkg::CFG_GAIN_P, 24'h7FFFFF);
        write_reg(pwt_pkg::CFG_GAIN_I, 24'h800000);
        write_reg(pwt_pkg::CFG_GAIN_D, 24'h7FFFFF);
        write_reg(pwt_pkg::CFG_STEP_P, 24'hFFFFFF);
        write_reg(pwt_pkg::CFG_STEP_I, 24'h7FFFFF);
        write_reg(pwt_pkg::CFG_STEP_D, 24'd0);
        write_reg(pwt_pkg::CFG_WARMUP, 24'd0);
        write_reg(pwt_pkg::CFG_MIN_RUN, 24'd0);
        for (int k = 0; k < 3; k++) queue_word(pwt_pkg::OP_SAMPLE, 32767);
        queue_word(pwt_pkg::OP_TUNE, 0);
        for (int k = 0; k < 3; k++) queue_word(pwt_pkg::OP_SAMPLE, -32768);
        queue_word(pwt_pkg::OP_TUNE, 0);
        queue_word(pwt_pkg::OP_TUNE, 0);
        queue_word(pwt_pkg::OP_SAMPLE, 0);
        queue_word(pwt_pkg::OP_TUNE, 0);
        queue_word(pwt_pkg::OP_TUNE, 0);
        wait_drained();

        // Longest warm-up and run length: every mean saturates.
        write_reg(pwt_pkg::CFG_WARMUP, 24'hFFFF);
        write_reg(pwt_pkg::CFG_MIN_RUN, 24'hFFFF);
        send_idle_pct = 8; recv_idle_pct = 76;
        queue_runs(40, 1'b1);
        wait_drained();

        // Random phases under three idling patterns.
        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 8 : (p < 4) ? 76 : 0;
            recv_idle_pct = (p < 2) ? 76 : (p < 4) ? 8 : 0;
            random_config();
            queue_runs(75, p == 3);
            wait_drained();
        end

        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule
